// ----- design/memory_lcd_shadow_line_framer_defines.svh -----
// Assertion macros for the memory LCD shadow line framer.
// Used by the controller and datapath modules; expects clk and arst_n in scope.
`ifndef MEMORY_LCD_SHADOW_LINE_FRAMER_DEFINES_SVH
`define MEMORY_LCD_SHADOW_LINE_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MLSF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MLSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/mlsf_pkg.sv -----
// Shared types, panel geometry and frame constants for the shadow line framer.
// No dependencies; imported by every other file of the block except the macro header.
package mlsf_pkg;

	localparam int PANEL_WIDTH  = 176;
	localparam int PANEL_HEIGHT = 176;

	localparam int ROW_BYTES   = PANEL_WIDTH / 2;
	localparam int ROW_WORDS   = (ROW_BYTES + 3) / 4;
	localparam int STORE_WORDS = ROW_WORDS * PANEL_HEIGHT;
	localparam int FRAME_WORDS = ROW_WORDS + 1;
	localparam int ADDR_W      = $clog2(STORE_WORDS);
	localparam int K_W         = $clog2(FRAME_WORDS);

	localparam int POS_W   = 9;
	localparam int COLOR_W = 16;
	localparam int WORD_W  = 32;

	localparam logic [7:0]  CMD_UPDATE   = 8'h90;
	localparam logic [7:0]  CMD_POLARITY = 8'h40;
	localparam logic [15:0] RED_MASK     = 16'hF800;
	localparam logic [15:0] GREEN_MASK   = 16'h07E0;
	localparam logic [15:0] BLUE_MASK    = 16'h001F;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STREAM
	} mlsf_state_t;

	typedef struct packed {
		logic clr_step;
		logic pix_write;
		logic flush_start;
		logic word_step;
	} mlsf_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic pix_ok;
		logic row_ok;
		logic out_free;
		logic word_last;
	} mlsf_stat_t;

endpackage

// ----- design/mlsf_if.sv -----
// Valid/ready channel interfaces for the framer input items and output words.
// Depends on mlsf_pkg for field widths.
interface mlsf_in_if
	import mlsf_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [POS_W-1:0]   col_pos;
	logic [POS_W-1:0]   row_pos;
	logic [COLOR_W-1:0] pixel_color;

	modport source (output valid, kind, col_pos, row_pos, pixel_color, input ready);
	modport sink (input valid, kind, col_pos, row_pos, pixel_color, output ready);
endinterface

interface mlsf_out_if
	import mlsf_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] frame_word;
	logic              last;

	modport source (output valid, frame_word, last, input ready);
	modport sink (input valid, frame_word, last, output ready);
endinterface

// ----- design/memory_lcd_shadow_line_framer.sv -----
// Top level of the memory LCD shadow line framer: config register and the
// controller/datapath pair. Depends on mlsf_pkg, mlsf_if, mlsf_ctrl, mlsf_datapath.
//
//   port      dir  beat contents
//   --------  ---  ---------------------------------------------------
//   in_ch     in   kind, col_pos, row_pos, pixel_color (write or flush)
//   out_ch    out  frame_word (32 b, first byte on top), last
//   cfg_wr_*  in   com_polarity, one bit, no handshake
//
// After reset the store is swept to white, one 32-bit word a cycle, with
// in_ch.ready low. The store has nibble write lanes, so a pixel write needs no
// read-modify-write. A flush of an on-panel row streams 23 words, one per cycle
// while out_ch is ready, from the store's single read port, then returns to idle.
// Off-panel items are accepted and dropped. A stalled out_ch holds the streaming
// word and the store read in place.
module memory_lcd_shadow_line_framer
	import mlsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	mlsf_in_if.sink           in_ch,
	mlsf_out_if.source        out_ch
);

	// command polarity bit, read directly while a frame is built
	logic       com_polarity_q;
	mlsf_cmd_t  cmd;
	mlsf_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			com_polarity_q <= 1'b0;
		end else if (cfg_wr_en) begin
			com_polarity_q <= cfg_wr_data;
		end
	end

	// sequence clear, writes and flushes
	mlsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.stat     (stat),
		.in_ready (in_ch.ready),
		.cmd      (cmd)
	);

	// store, address math, frame assembly and the output register
	mlsf_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.com_polarity (com_polarity_q),
		.kind         (in_ch.kind),
		.col_pos      (in_ch.col_pos),
		.row_pos      (in_ch.row_pos),
		.pixel_color  (in_ch.pixel_color),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.frame_word   (out_ch.frame_word),
		.last         (out_ch.last)
	);

endmodule

// ----- design/mlsf_ctrl.sv -----
// Controller state machine: clear sweep, item acceptance, row streaming.
// Depends on mlsf_pkg and the assertion macro header.
`include "memory_lcd_shadow_line_framer_defines.svh"

module mlsf_ctrl
	import mlsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_kind,
	input  mlsf_stat_t stat,
	output logic       in_ready,
	output mlsf_cmd_t  cmd
);

	mlsf_state_t state_q;
	mlsf_state_t state_d;
	logic        accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && in_kind == KIND_FLUSH && stat.row_ok) begin
					state_d = ST_STREAM;
				end
			end
			ST_STREAM: begin
				if (stat.out_free && stat.word_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// ready is high throughout idle, so a valid beat there is an accepted one
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.pix_write   = in_valid && in_kind == KIND_PIXEL && stat.pix_ok;
				cmd.flush_start = in_valid && in_kind == KIND_FLUSH && stat.row_ok;
			end
			ST_STREAM: begin
				cmd.word_step = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`MLSF_ASSERT_NEXT(a_clear_done, state_q == ST_CLEAR && stat.clr_last, state_q == ST_IDLE, "clear sweep did not hand over to idle")
	`MLSF_ASSERT_NOW(a_no_item_in_clear, state_q == ST_CLEAR, !(cmd.pix_write || cmd.flush_start), "item taken during clear sweep")
	`MLSF_ASSERT_NEXT(a_flush_streams, cmd.flush_start, state_q == ST_STREAM, "accepted flush did not start streaming")

endmodule

// ----- design/mlsf_datapath.sv -----
// Datapath: shadow store memory, pixel address and nibble logic, frame word
// assembly and output register. Depends on mlsf_pkg and the macro header.
`include "memory_lcd_shadow_line_framer_defines.svh"

module mlsf_datapath
	import mlsf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  mlsf_cmd_t          cmd,
	output mlsf_stat_t         stat,
	input  logic               com_polarity,
	input  logic               kind,
	input  logic [POS_W-1:0]   col_pos,
	input  logic [POS_W-1:0]   row_pos,
	input  logic [COLOR_W-1:0] pixel_color,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [WORD_W-1:0]  frame_word,
	output logic               last
);

	// store, eight nibble lanes per word, lane 7 is the earliest pixel
	logic [7:0][3:0] store_mem [STORE_WORDS];

	logic [7:0]        half;
	logic              half_wrap;
	logic [7:0]        half_eff;
	logic [POS_W:0]    row_eff;
	logic [POS_W:0]    mul_row;
	logic [ADDR_W-1:0] row_base;
	logic [ADDR_W-1:0] pix_addr;
	logic [2:0]        lane;
	logic [3:0]        nibble;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_mask;
	logic [3:0]        wr_nib;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;

	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] nxt_rd_q;
	logic [K_W-1:0]    k_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] rd_data_q;
	logic [15:0]       prev_lo_q;
	logic [7:0]        addr_byte_q;
	logic [WORD_W-1:0] frame_word_q;
	logic              last_q;

	logic [7:0]        cmd_byte;
	logic [WORD_W-1:0] raw_word;
	logic [WORD_W-1:0] masked_word;

	// Pixel addressing; an odd width's last column spills into the next row's first byte.
	assign half      = col_pos[POS_W-1:1];
	assign half_wrap = (half == 8'(ROW_BYTES));
	assign half_eff  = half_wrap ? 8'h00 : half;
	assign row_eff   = {1'b0, row_pos} + (POS_W+1)'(half_wrap);
	assign mul_row   = (kind == KIND_FLUSH) ? {1'b0, row_pos} : row_eff;
	assign row_base  = ADDR_W'(32'(mul_row) * ROW_WORDS);
	assign pix_addr  = row_base + ADDR_W'(half_eff[7:2]);
	assign lane      = ~{half_eff[1:0], col_pos[0]};

	assign nibble = {|(pixel_color & RED_MASK), |(pixel_color & GREEN_MASK),
		|(pixel_color & BLUE_MASK), 1'b0};

	assign stat.pix_ok    = (col_pos < POS_W'(PANEL_WIDTH)) &&
		(row_eff < (POS_W+1)'(PANEL_HEIGHT));
	assign stat.row_ok    = row_pos < POS_W'(PANEL_HEIGHT);
	assign stat.clr_last  = clr_addr_q == ADDR_W'(STORE_WORDS - 1);
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.word_last = k_q == K_W'(FRAME_WORDS - 1);

	assign wr_en   = cmd.clr_step || cmd.pix_write;
	assign wr_addr = cmd.clr_step ? clr_addr_q : pix_addr;
	assign wr_mask = cmd.clr_step ? 8'hFF : (8'h01 << lane);
	assign wr_nib  = cmd.clr_step ? 4'hF : nibble;

	// read word k+1 while word k leaves; no read past the row
	assign rd_en   = cmd.flush_start || (cmd.word_step && (k_q < K_W'(ROW_WORDS - 1)));
	assign rd_addr = cmd.flush_start ? row_base : nxt_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < 8; i++) begin
				if (wr_mask[i]) begin
					store_mem[wr_addr][i] <= wr_nib;
				end
			end
		end
		if (rd_en) begin
			rd_data_q <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			nxt_rd_q    <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (rd_en) begin
				nxt_rd_q <= rd_addr + ADDR_W'(1);
			end
			if (cmd.flush_start) begin
				k_q <= '0;
			end else if (cmd.word_step) begin
				k_q <= stat.word_last ? '0 : k_q + K_W'(1);
			end
			if (cmd.word_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush_start) begin
			addr_byte_q <= 8'({1'b0, row_pos} + (POS_W+1)'(1));
		end
		if (cmd.word_step) begin
			prev_lo_q    <= rd_data_q[15:0];
			frame_word_q <= masked_word;
			last_q       <= stat.word_last;
		end
	end

	assign cmd_byte = CMD_UPDATE | (com_polarity ? CMD_POLARITY : 8'h00);

	// Frame bytes past the row data (trailer and padding) read as zero.
	always_comb begin
		logic [K_W+1:0] byte_idx;
		raw_word = (k_q == '0) ? {cmd_byte, addr_byte_q, rd_data_q[31:16]}
			: {prev_lo_q, rd_data_q[31:16]};
		for (int b = 0; b < 4; b++) begin
			byte_idx = {k_q, 2'b00} + (K_W+2)'(b);
			masked_word[31-8*b -: 8] = (byte_idx < (K_W+2)'(ROW_BYTES + 2))
				? raw_word[31-8*b -: 8] : 8'h00;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_word = frame_word_q;
	assign last       = last_q;

	`MLSF_ASSERT_NOW(a_k_bound, 1'b1, k_q <= K_W'(FRAME_WORDS - 1), "word index ran past frame")
	`MLSF_ASSERT_NEXT(a_last_out, cmd.word_step && stat.word_last, out_valid_q && last_q, "final word not flagged last")
	`MLSF_ASSERT_NOW(a_wr_not_stream, wr_en, !cmd.word_step && !cmd.flush_start, "store write during row read")

endmodule
